FILE: src/lsharp_pkg.sv
// shared types and constants of the 3x3 laplacian sharpening core
// no dependencies
package lsharp_pkg;

    localparam int MaxWidth   = 1024;
    localparam int MaxHeight  = 4096;
    localparam int PixW       = 8;
    localparam int WidthRegW  = 11;
    localparam int HeightRegW = 13;
    localparam int WeightW    = 8;
    localparam int CfgDataW   = 13;
    localparam int CfgIdxW    = 2;
    localparam int ColW       = $clog2(MaxWidth);
    localparam int RowW       = $clog2(MaxHeight) + 1;
    localparam int LapW       = PixW + 3;
    localparam int ProdW      = LapW + WeightW;
    localparam int ResW       = ProdW + 1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_SHARPEN_WEIGHT = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic            command;
        logic [PixW-1:0] pixel_in;
    } t_in_req;

    typedef struct packed {
        logic [PixW-1:0] pixel_out;
        logic            frame_last;
    } t_out_req;

    typedef struct packed {
        logic            started;
        logic            border;
        logic            last;
        logic [ColW-1:0] addr;
        logic [PixW-1:0] pix;
    } t_item_info;

endpackage

FILE: src/laplacian_sharpen_3x3_core.sv
// top level of the 3x3 laplacian sharpening core: line store, read stage, result register
// depends on lsharp_pkg, lsharp_ram, lsharp_pos, lsharp_win
//
//   channel  | valid        | stall        | payload / data
//   ---------+--------------+--------------+--------------------------------
//   input    | i_in_valid   | o_in_stall   | i_in_req  (command, pixel_in)
//   output   | o_out_valid  | i_out_stall  | o_out_req (pixel_out, frame_last)
//   config   | i_cfg_wr_en  | -            | i_cfg_index, i_cfg_data
//
// one request per cycle while o_in_stall is low; a result passes through the read stage and then the result register
// the two line stores share one ram; its registered read sets the read stage
// a flush request while the frame is still coming in is taken and dropped
// synchronous active-low reset clears counters, window and valid flags, not the ram
// an output stall fills the result register, then the read stage, then stalls the input
module laplacian_sharpen_3x3_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  lsharp_pkg::t_in_req             i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lsharp_pkg::t_out_req            o_out_req,
    input  logic                            i_cfg_wr_en,
    input  logic [lsharp_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [lsharp_pkg::CfgDataW-1:0] i_cfg_data
);
    import lsharp_pkg::*;

    logic            out_ready;
    logic            s1_free;
    logic            in_accept;
    logic            pos_take;
    logic            enter;
    logic            s1_leave;
    t_item_info      item;
    logic [WeightW-1:0] weight;

    logic            r_s1_valid;
    t_item_info      r_s1_info;
    logic            r_byp_hit;
    logic [2*PixW-1:0] r_byp_data;
    logic            r_out_valid;
    t_out_req        r_out_req;

    logic [2*PixW-1:0] ram_q;
    logic [2*PixW-1:0] rd_pair;
    logic [2*PixW-1:0] wr_pair;
    logic [PixW-1:0]   up_s1;
    logic [PixW-1:0]   mid_s1;
    logic [PixW-1:0]   res_pixel;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_ready;
    assign o_in_stall = !s1_free;
    assign in_accept  = i_in_valid && s1_free;
    assign enter      = in_accept && pos_take;
    assign s1_leave   = r_s1_valid && out_ready;

    lsharp_pos u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_req       (i_in_req),
        .o_take      (pos_take),
        .o_item      (item),
        .o_weight    (weight)
    );

    // entry holds {upper, middle}
    lsharp_ram #(
        .Width (2 * PixW),
        .Depth (MaxWidth)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_leave),
        .i_wr_addr (r_s1_info.addr),
        .i_wr_data (wr_pair),
        .i_rd_en   (enter),
        .i_rd_addr (item.addr),
        .o_rd_data (ram_q)
    );

    assign rd_pair = r_byp_hit ? r_byp_data : ram_q;
    assign up_s1   = rd_pair[2*PixW-1:PixW];
    assign mid_s1  = rd_pair[PixW-1:0];
    assign wr_pair = {mid_s1, r_s1_info.pix};

    lsharp_win u_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (s1_leave),
        .i_up     (up_s1),
        .i_mid    (mid_s1),
        .i_pix    (r_s1_info.pix),
        .i_border (r_s1_info.border),
        .i_weight (weight),
        .o_pixel  (res_pixel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp_hit  <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= enter;
            if (enter) begin
                r_byp_hit <= s1_leave && (r_s1_info.addr == item.addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enter) begin
            r_s1_info  <= item;
            r_byp_data <= wr_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= s1_leave && r_s1_info.started;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && s1_leave && r_s1_info.started) begin
            r_out_req.pixel_out  <= res_pixel;
            r_out_req.frame_last <= r_s1_info.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    a_bypass_on_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        enter && s1_leave && (r_s1_info.addr == item.addr) |=> r_byp_hit)
        else $error("line store bypass missed a same-address access");

    a_dropped_flush_no_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !pos_take |=> !r_s1_valid)
        else $error("dropped flush request occupied the read stage");

    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_valid && r_s1_info.started))
        else $error("result appeared without a started item in the read stage");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && i_out_stall |-> !in_accept)
        else $error("request taken while both stages are blocked");

endmodule

FILE: src/lsharp_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module lsharp_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(Depth)-1:0] i_wr_addr,
    input  logic [Width-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(Depth)-1:0] i_rd_addr,
    output logic [Width-1:0]         o_rd_data
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/lsharp_pos.sv
// configuration registers and frame position counters
// depends on lsharp_pkg
module lsharp_pos (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [lsharp_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [lsharp_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  lsharp_pkg::t_in_req            i_req,
    output logic                           o_take,
    output lsharp_pkg::t_item_info         o_item,
    output logic [lsharp_pkg::WeightW-1:0] o_weight
);
    import lsharp_pkg::*;

    logic [WidthRegW-1:0]  r_width;
    logic [HeightRegW-1:0] r_height;
    logic [WeightW-1:0]    r_weight;
    logic [ColW-1:0]       r_col, n_col;
    logic [RowW-1:0]       r_row, n_row;

    logic [WidthRegW-1:0]  eff_w;
    logic [HeightRegW-1:0] eff_h;
    logic                  frame_in;
    logic                  started;
    logic [RowW-1:0]       orow;
    logic [ColW-1:0]       ocol;
    logic [ColW:0]         col_inc;
    logic [RowW:0]         orow_inc;
    logic [ColW:0]         ocol_inc;
    logic                  border;
    logic                  last;
    logic                  restart;

    always_comb begin
        if (r_width == '0) begin
            eff_w = WidthRegW'(1);
        end else if (r_width > WidthRegW'(MaxWidth)) begin
            eff_w = WidthRegW'(MaxWidth);
        end else begin
            eff_w = r_width;
        end
        if (r_height == '0) begin
            eff_h = HeightRegW'(1);
        end else if (r_height > HeightRegW'(MaxHeight)) begin
            eff_h = HeightRegW'(MaxHeight);
        end else begin
            eff_h = r_height;
        end
    end

    always_comb begin
        frame_in = r_row < RowW'(eff_h);
        started  = (r_row > RowW'(1)) || ((r_row == RowW'(1)) && (r_col != '0));
        if (r_col != '0) begin
            orow = r_row - RowW'(1);
            ocol = r_col - ColW'(1);
        end else begin
            orow = r_row - RowW'(2);
            ocol = ColW'(eff_w - WidthRegW'(1));
        end
        orow_inc = {1'b0, orow} + (RowW + 1)'(1);
        ocol_inc = {1'b0, ocol} + (ColW + 1)'(1);
        border   = (orow == '0) || (ocol == '0)
                || (orow_inc >= (RowW + 1)'(eff_h)) || (ocol_inc >= (ColW + 1)'(eff_w));
        last     = started && (orow_inc == (RowW + 1)'(eff_h))
                && (ocol_inc == (ColW + 1)'(eff_w));
        o_take   = !(i_req.command && frame_in);

        col_inc = {1'b0, r_col} + (ColW + 1)'(1);
        if (col_inc >= (ColW + 1)'(eff_w)) begin
            n_col = '0;
            n_row = r_row + RowW'(1);
        end else begin
            n_col = col_inc[ColW-1:0];
            n_row = r_row;
        end

        restart = i_cfg_wr_en && ((i_cfg_index == CFG_IMAGE_WIDTH)
                               || (i_cfg_index == CFG_IMAGE_HEIGHT));

        o_item.started = started;
        o_item.border  = border;
        o_item.last    = last;
        o_item.addr    = r_col;
        o_item.pix     = frame_in ? i_req.pixel_in : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WidthRegW'(512);
            r_height <= HeightRegW'(512);
            r_weight <= WeightW'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:    r_width  <= i_cfg_data[WidthRegW-1:0];
                CFG_IMAGE_HEIGHT:   r_height <= i_cfg_data[HeightRegW-1:0];
                CFG_SHARPEN_WEIGHT: r_weight <= i_cfg_data[WeightW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept && o_take) begin
            if (last) begin
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    assign o_weight = r_weight;

endmodule

FILE: src/lsharp_win.sv
// window registers and laplacian sharpening arithmetic with clamp
// depends on lsharp_pkg
module lsharp_win (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  logic [lsharp_pkg::PixW-1:0]    i_up,
    input  logic [lsharp_pkg::PixW-1:0]    i_mid,
    input  logic [lsharp_pkg::PixW-1:0]    i_pix,
    input  logic                           i_border,
    input  logic [lsharp_pkg::WeightW-1:0] i_weight,
    output logic [lsharp_pkg::PixW-1:0]    o_pixel
);
    import lsharp_pkg::*;

    logic [PixW-1:0] r_col1 [3];
    logic [PixW-1:0] r_col2 [3];

    logic [PixW-1:0]         center;
    logic [LapW-1:0]         nsum;
    logic signed [LapW-1:0]  lap;
    logic signed [ProdW-1:0] prod;
    logic signed [ResW-1:0]  res;

    always_comb begin
        center = r_col2[1];
        nsum   = LapW'(r_col2[0]) + LapW'(r_col2[2]) + LapW'(r_col1[1]) + LapW'(i_mid);
        lap    = i_border ? '0 : $signed(nsum - LapW'({center, 2'b00}));
        prod   = ProdW'($signed(i_weight)) * ProdW'(lap);
        res    = ResW'($signed({1'b0, center})) - ResW'(prod);
        if (res < 0) begin
            o_pixel = '0;
        end else if (res > ResW'(255)) begin
            o_pixel = '1;
        end else begin
            o_pixel = res[PixW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_col1[k] <= '0;
                r_col2[k] <= '0;
            end
        end else if (i_shift) begin
            for (int k = 0; k < 3; k++) begin
                r_col1[k] <= r_col2[k];
            end
            r_col2[0] <= i_up;
            r_col2[1] <= i_mid;
            r_col2[2] <= i_pix;
        end
    end

endmodule
